[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RGA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the clock cycle after the trigger.
`define RGA_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[design/rga_pkg.sv]
// Shared constants and types of the RMS gated automatic gain block.
`default_nettype none
package rga_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int NUM_CH           = 4;

    localparam int CFG_W     = 47;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 3'd5;

    localparam int GAIN_W   = 24;
    localparam int COEFF_W  = 24;
    localparam int TARGET_W = 23;
    localparam int MS_W     = 47;
    localparam int ST_W     = 48;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd2097152;
    localparam logic [GAIN_W-1:0] MIN_GAIN   = 24'd526781;
    localparam logic [GAIN_W-1:0] MAX_GAIN   = 24'd8348912;
    localparam logic [MS_W-1:0]   MS_FLOOR   = 47'd7037;

    localparam logic [2:0]          RST_CHANNELS = 3'd2;
    localparam logic [COEFF_W-1:0]  RST_DET_COEF = 24'd2196;
    localparam logic [COEFF_W-1:0]  RST_REL_COEF = 24'd699;
    localparam logic [TARGET_W-1:0] RST_TARGET   = 23'd1056164;
    localparam logic [MS_W-1:0]     RST_GATE     = 47'd703687442;

    // Shared multiplier, divider and square root widths
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int NUM_W     = 52;
    localparam int DEN_W     = 32;
    localparam int SQRT_IN_W = 64;
    localparam int ROOT_W    = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } rga_unit_stat_t;

endpackage
`default_nettype wire

[design/rga_if.sv]
// Input frame and output frame channel interfaces.
`default_nettype none
interface rga_in_if import rga_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ch0_sample;
    logic signed [SAMPLE_BITS-1:0] ch1_sample;
    logic signed [SAMPLE_BITS-1:0] ch2_sample;
    logic signed [SAMPLE_BITS-1:0] ch3_sample;

    modport source (output valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample,
                    input ready);
    modport sink (input valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample,
                  output ready);
endinterface

interface rga_out_if import rga_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ch0_out;
    logic signed [SAMPLE_BITS-1:0] ch1_out;
    logic signed [SAMPLE_BITS-1:0] ch2_out;
    logic signed [SAMPLE_BITS-1:0] ch3_out;
    logic        [GAIN_W-1:0]      applied_gain;

    modport source (output valid, ch0_out, ch1_out, ch2_out, ch3_out, applied_gain,
                    input ready);
    modport sink (input valid, ch0_out, ch1_out, ch2_out, ch3_out, applied_gain,
                  output ready);
endinterface
`default_nettype wire

[design/rga_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rga_div import rga_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output rga_unit_stat_t        stat
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diffv;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diffv   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                den_reg  <= den;
                quo_reg  <= num;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diffv[DEN_W-1:0] : shifted[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

[design/rga_sqrt.sv]
// Integer square root, one root bit per cycle.
`default_nettype none
module rga_sqrt import rga_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [SQRT_IN_W-1:0] val,
    output logic      [ROOT_W-1:0]    root,
    output rga_unit_stat_t            stat
);
    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SQRT_IN_W-1:0] val_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [REM_W+1:0]     sh;
    logic [REM_W+1:0]     trial;
    logic                 fits;

    always_comb
    begin
        sh    = {rem_reg, val_reg[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        fits  = sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                val_reg  <= val;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                val_reg  <= {val_reg[SQRT_IN_W-3:0], 2'b00};
                rem_reg  <= fits ? REM_W'(sh - trial) : REM_W'(sh);
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule
`default_nettype wire

[design/rms_gated_auto_gain.sv]
// RMS gated automatic gain control: sequencer, shared multiplier and state.
// Above the gate a frame runs two 52-step divisions (mean, target/root) and a 32-step
//   square root; below the gate only the mean division runs, and when disabled a frame
//   goes straight from the idle state to the finish state.
// One frame is processed at a time; a new frame is taken as soon as the sequencer is
//   back in idle, even while the last result waits in the output register.
// Reset: registers return to their defaults, detector at zero, gain at unity.
`default_nettype none
module rms_gated_auto_gain import rga_pkg::*; #(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    rga_in_if.sink                    in_ch,
    rga_out_if.source                 out_ch
);
    localparam int SB      = SAMPLE_BITS;
    localparam int SQ_DOWN = (SB > 24) ? 2 * (SB - 24) : 0;
    localparam int SQ_UP   = (SB < 24) ? 2 * (24 - SB) : 0;
    localparam int SUM_W   = MS_W + 2;
    localparam int Y_W     = ST_W + 2;
    localparam logic [2:0] MAX_N = 3'(MAX_CHANNELS);
    localparam logic signed [PROD_W-1:0] S_MAX = PROD_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] S_MIN = -S_MAX - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] RND   = PROD_W'(64'sd1 <<< 20);
    localparam logic signed [Y_W:0] ST_HI = (Y_W+1)'(64'sd140737488355327);
    localparam logic signed [Y_W:0] ST_LO = -ST_HI - (Y_W+1)'(1);
    localparam logic signed [Y_W-1:0] Y_FLOOR = Y_W'(MS_FLOOR);
    localparam logic signed [Y_W-1:0] Y_MAX   = Y_W'(64'sd140737488355327);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_SQ_MUL   = 16'h0002,
        S_SQ_ACC   = 16'h0004,
        S_MEAN     = 16'h0008,
        S_MEAN_WT  = 16'h0010,
        S_MQ_LO    = 16'h0020,
        S_MQ_HI    = 16'h0040,
        S_TPT_UPD  = 16'h0080,
        S_SQRT     = 16'h0100,
        S_DIVG     = 16'h0200,
        S_GSET     = 16'h0400,
        S_GAIN_UPD = 16'h0800,
        S_OUT_MUL  = 16'h1000,
        S_OUT_ACC  = 16'h2000,
        S_FINISH   = 16'h4000,
        S_MQ_DONE  = 16'h8000
    } rga_state_t;

    // Configuration registers
    logic                enable_reg;
    logic [2:0]          channels_reg;
    logic [COEFF_W-1:0]  det_coef_reg;
    logic [COEFF_W-1:0]  rel_coef_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [MS_W-1:0]     gate_reg;

    // Sequencer and datapath state
    rga_state_t                state_reg, state_next;
    logic [2:0]                n_reg;
    logic [1:0]                k_reg;
    logic signed [SB-1:0]      smp_reg [NUM_CH];
    logic signed [SB-1:0]      res_reg [NUM_CH];
    logic [GAIN_W-1:0]         res_gain_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic signed [ST_W-1:0]    det_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic [GAIN_W-1:0]         wanted_reg;
    logic [ST_W-1:0]           mq_mag_reg;
    logic                      mq_neg_reg;
    logic [COEFF_W-1:0]        mq_coef_reg;
    logic                      mq_gain_reg;   // 1: gain update, 0: detector update
    logic [COEFF_W-1:0]        mq_lo_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      out_valid_reg;
    logic signed [SB-1:0]      out_smp_reg [NUM_CH];
    logic [GAIN_W-1:0]         out_gain_reg;

    // Combinational datapath
    logic signed [MUL_W-1:0]   mul_a, mul_b, smp_ext, smp_mag;
    logic [PROD_W-1:0]         sq_full;
    logic [MS_W-1:0]           sq_scaled;
    logic signed [ST_W:0]      mean_diff;
    logic [ST_W:0]             mean_mag;
    logic [ST_W:0]             mq_p;
    logic signed [Y_W-1:0]     mq_v;
    logic signed [Y_W-1:0]     y_raw;
    logic signed [Y_W:0]       ns_raw;
    logic signed [ST_W-1:0]    ns_sat;
    logic [MS_W-1:0]           y_clamp;
    logic                      gate_open;
    logic signed [GAIN_W:0]    gain_diff;
    logic signed [Y_W:0]       gain_sum;
    logic signed [PROD_W-1:0]  out_rnd;
    logic signed [SB-1:0]      out_sat;
    logic [NUM_W-1:0]          div_quo;
    logic [GAIN_W-1:0]         div_clamp;
    logic [ROOT_W-1:0]         sq_root;
    rga_unit_stat_t            div_stat, sqrt_stat;
    logic                      div_start, sqrt_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [2:0]                n_clamp;
    logic                      in_beat, out_free, k_last;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign in_beat        = in_ch.valid && in_ch.ready;
    assign out_free       = !out_valid_reg || out_ch.ready;
    assign k_last         = (k_reg == 2'(n_reg - 3'd1));

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.ch0_out      = out_smp_reg[0];
    assign out_ch.ch1_out      = out_smp_reg[1];
    assign out_ch.ch2_out      = out_smp_reg[2];
    assign out_ch.ch3_out      = out_smp_reg[3];
    assign out_ch.applied_gain = out_gain_reg;

    // Channel count: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (channels_reg == 3'd0)
            n_clamp = 3'd1;
        else if (channels_reg > MAX_N)
            n_clamp = MAX_N;
        else
            n_clamp = channels_reg;
    end

    // Shared multiplier operand select
    always_comb
    begin
        smp_ext = MUL_W'(smp_reg[k_reg]);
        smp_mag = (smp_ext < 0) ? -smp_ext : smp_ext;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = smp_mag;
                mul_b = smp_mag;
            end
            S_MQ_LO:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, mq_mag_reg[23:0]};
                mul_b = {{(MUL_W-COEFF_W){1'b0}}, mq_coef_reg};
            end
            S_MQ_HI:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, mq_mag_reg[ST_W-1:24]};
                mul_b = {{(MUL_W-COEFF_W){1'b0}}, mq_coef_reg};
            end
            // high partial product held for the update state that follows
            S_MQ_DONE:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, mq_mag_reg[ST_W-1:24]};
                mul_b = {{(MUL_W-COEFF_W){1'b0}}, mq_coef_reg};
            end
            S_OUT_MUL:
            begin
                mul_a = smp_ext;
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        // Square scaled to Q0.46
        sq_full   = $unsigned(prod_reg);
        sq_scaled = MS_W'((sq_full >> SQ_DOWN) << SQ_UP);

        // Detector input minus integrator
        mean_diff = $signed({2'b00, div_quo[MS_W-1:0]}) - (ST_W+1)'(det_reg);
        mean_mag  = (mean_diff < 0) ? $unsigned(-mean_diff) : $unsigned(mean_diff);

        // Truncated-toward-zero product by a Q0.24 coefficient
        mq_p = (ST_W+1)'(prod_reg[ST_W-1:0]) + (ST_W+1)'(mq_lo_reg);
        mq_v = mq_neg_reg ? -$signed({1'b0, mq_p}) : $signed({1'b0, mq_p});

        // TPT lowpass update with saturation of the integrator
        y_raw  = Y_W'(det_reg) + mq_v;
        ns_raw = (Y_W+1)'(y_raw) + (Y_W+1)'(mq_v);
        if (ns_raw > ST_HI)
            ns_sat = ST_W'(ST_HI);
        else if (ns_raw < ST_LO)
            ns_sat = ST_W'(ST_LO);
        else
            ns_sat = ST_W'(ns_raw);
        if (y_raw < Y_FLOOR)
            y_clamp = MS_FLOOR;
        else if (y_raw > Y_MAX)
            y_clamp = MS_W'(Y_MAX);
        else
            y_clamp = MS_W'(y_raw);
        gate_open = y_clamp > gate_reg;

        // Wanted gain clamped to +-12 dB
        if (div_quo < NUM_W'(MIN_GAIN))
            div_clamp = MIN_GAIN;
        else if (div_quo > NUM_W'(MAX_GAIN))
            div_clamp = MAX_GAIN;
        else
            div_clamp = div_quo[GAIN_W-1:0];

        gain_diff = $signed({1'b0, wanted_reg}) - $signed({1'b0, gain_reg});
        gain_sum  = $signed({{(Y_W+1-GAIN_W){1'b0}}, gain_reg}) + (Y_W+1)'(mq_v);

        // Output: round half up, saturate to the sample range
        out_rnd = (prod_reg + RND) >>> 21;
        if (out_rnd > S_MAX)
            out_sat = SB'(S_MAX);
        else if (out_rnd < S_MIN)
            out_sat = SB'(S_MIN);
        else
            out_sat = SB'(out_rnd);
    end

    // The divider is shared between the two phases of a frame; the square root serves the second
    assign div_start  = (state_reg == S_MEAN) || ((state_reg == S_SQRT) && sqrt_stat.done);
    assign div_num    = (state_reg == S_MEAN) ? NUM_W'(sum_reg) : {target_reg, 29'd0};
    assign div_den    = (state_reg == S_MEAN) ? DEN_W'(n_reg) : sq_root;
    assign sqrt_start = (state_reg == S_TPT_UPD) && gate_open;

    rga_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    rga_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   ({1'b0, y_clamp, 16'd0}),
        .root  (sq_root),
        .stat  (sqrt_stat)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_beat) state_next = enable_reg ? S_SQ_MUL : S_FINISH;
            S_SQ_MUL:   state_next = S_SQ_ACC;
            S_SQ_ACC:   state_next = k_last ? S_MEAN : S_SQ_MUL;
            S_MEAN:     state_next = S_MEAN_WT;
            S_MEAN_WT:  if (div_stat.done) state_next = S_MQ_LO;
            S_MQ_LO:    state_next = S_MQ_HI;
            S_MQ_HI:    state_next = S_MQ_DONE;
            S_MQ_DONE:  state_next = mq_gain_reg ? S_GAIN_UPD : S_TPT_UPD;
            S_TPT_UPD:  state_next = gate_open ? S_SQRT : S_GSET;
            S_SQRT:     if (sqrt_stat.done) state_next = S_DIVG;
            S_DIVG:     if (div_stat.done && !div_stat.busy) state_next = S_GSET;
            S_GSET:     state_next = S_MQ_LO;
            S_GAIN_UPD: state_next = S_OUT_MUL;
            S_OUT_MUL:  state_next = S_OUT_ACC;
            S_OUT_ACC:  state_next = k_last ? S_FINISH : S_OUT_MUL;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b1;
            channels_reg  <= RST_CHANNELS;
            det_coef_reg  <= RST_DET_COEF;
            rel_coef_reg  <= RST_REL_COEF;
            target_reg    <= RST_TARGET;
            gate_reg      <= RST_GATE;
            det_reg       <= '0;
            gain_reg      <= UNITY_GAIN;
            out_valid_reg <= 1'b0;
            n_reg         <= 3'd1;
            k_reg         <= '0;
            sum_reg       <= '0;
            wanted_reg    <= UNITY_GAIN;
            mq_mag_reg    <= '0;
            mq_neg_reg    <= 1'b0;
            mq_coef_reg   <= '0;
            mq_gain_reg   <= 1'b0;
            mq_lo_reg     <= '0;
            prod_reg      <= '0;
            res_gain_reg  <= UNITY_GAIN;
            out_gain_reg  <= UNITY_GAIN;
            for (int i = 0; i < NUM_CH; i++)
            begin
                smp_reg[i]     <= '0;
                res_reg[i]     <= '0;
                out_smp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= mul_a * mul_b;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:   enable_reg   <= cfg_data[0];
                    CFG_CHANNELS: channels_reg <= cfg_data[2:0];
                    CFG_DET_COEF: det_coef_reg <= cfg_data[COEFF_W-1:0];
                    CFG_REL_COEF: rel_coef_reg <= cfg_data[COEFF_W-1:0];
                    CFG_TARGET:   target_reg   <= cfg_data[TARGET_W-1:0];
                    CFG_GATE:     gate_reg     <= cfg_data[MS_W-1:0];
                    default:      ;
                endcase
            end

            // the finish state loads the next beat itself
            if (out_valid_reg && out_ch.ready && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        smp_reg[0]   <= in_ch.ch0_sample;
                        smp_reg[1]   <= in_ch.ch1_sample;
                        smp_reg[2]   <= in_ch.ch2_sample;
                        smp_reg[3]   <= in_ch.ch3_sample;
                        // inactive channels and the disabled case pass through
                        res_reg[0]   <= in_ch.ch0_sample;
                        res_reg[1]   <= in_ch.ch1_sample;
                        res_reg[2]   <= in_ch.ch2_sample;
                        res_reg[3]   <= in_ch.ch3_sample;
                        res_gain_reg <= UNITY_GAIN;
                        n_reg        <= n_clamp;
                        k_reg        <= '0;
                        sum_reg      <= '0;
                    end
                end
                S_SQ_ACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(sq_scaled);
                    k_reg   <= k_reg + 2'd1;
                end
                S_MEAN_WT:
                begin
                    if (div_stat.done)
                    begin
                        mq_neg_reg  <= mean_diff < 0;
                        mq_mag_reg  <= mean_mag[ST_W-1:0];
                        mq_coef_reg <= det_coef_reg;
                        mq_gain_reg <= 1'b0;
                    end
                end
                S_MQ_HI:
                begin
                    mq_lo_reg <= prod_reg[47:24];
                end
                S_TPT_UPD:
                begin
                    det_reg <= ns_sat;
                    if (!gate_open)
                        wanted_reg <= UNITY_GAIN;
                end
                S_DIVG:
                begin
                    if (div_stat.done)
                        wanted_reg <= div_clamp;
                end
                S_GSET:
                begin
                    mq_neg_reg  <= gain_diff < 0;
                    mq_mag_reg  <= ST_W'((gain_diff < 0) ? -gain_diff : gain_diff);
                    mq_coef_reg <= rel_coef_reg;
                    mq_gain_reg <= 1'b1;
                end
                S_GAIN_UPD:
                begin
                    gain_reg     <= gain_sum[GAIN_W-1:0];
                    res_gain_reg <= gain_sum[GAIN_W-1:0];
                    k_reg        <= '0;
                end
                S_OUT_ACC:
                begin
                    res_reg[k_reg] <= out_sat;
                    k_reg          <= k_reg + 2'd1;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_gain_reg  <= res_gain_reg;
                        for (int i = 0; i < NUM_CH; i++)
                            out_smp_reg[i] <= res_reg[i];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/rga_checker.sv]
// Port-level checker for the gain block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rga_checker import rga_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [GAIN_W-1:0] applied_gain
);
    `RGA_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after input beat")
    `RGA_ASSERT(a_gain_range, !out_valid || (applied_gain >= MIN_GAIN && applied_gain <= MAX_GAIN), "gain out of range")
    `RGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(applied_gain), "stalled beat changed")
endmodule

bind rms_gated_auto_gain rga_checker u_rga_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .applied_gain (out_ch.applied_gain)
);
`default_nettype wire
